FILE: sv/signed_int_to_decimal_ascii_macros.svh
// Assertion macros used by the checker file.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication.
`define SITOA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define SITOA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/sitoa_pkg.sv
`timescale 1ns / 1ps

package sitoa_pkg;

  localparam int VALUE_W    = 32;
  localparam int NUM_DIGITS = 10;
  localparam int CNT_W      = $clog2(VALUE_W);
  localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  typedef logic [3:0] bcd_t;

  typedef struct packed {
    logic clr;
    logic conv;
    logic dshift;
  } cell_ctrl_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CONV = 5'b00010,
    S_SKIP = 5'b00100,
    S_SIGN = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

endpackage

FILE: sv/signed_int_to_decimal_ascii.sv
`timescale 1ns / 1ps

// Channel | Ports                                   | Direction
// --------+-----------------------------------------+----------
// input   | in_valid, in_ready, in_value[31:0]      | in
// result  | out_valid, out_ready, out_character,    | out
//         | out_last                                |
//
// One value at a time. After the input transaction, the magnitude is shifted
// bit by bit with add-3 adjust through a row of 10 BCD digit cells, then
// leading zeros are dropped, keeping at least one digit, then a minus sign
// for a negative value and the digits go out, one character per cycle while
// out_ready allows. Result stalls hold the output register and pause emission.
// Synchronous active-low reset clears the control state only.
module signed_int_to_decimal_ascii (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_character,
  output logic        out_last
);
  import sitoa_pkg::*;

  state_t                 state_r, state_nxt;
  logic [VALUE_W-1:0]     mag_r, mag_nxt;
  logic                   neg_r, neg_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [LEFT_W-1:0]      left_r, left_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;

  cell_ctrl_t             ctrl;
  logic                   chain_bit [NUM_DIGITS+1];
  bcd_t                   dig  [NUM_DIGITS];
  bcd_t                   din  [NUM_DIGITS];
  bcd_t                   top_digit;
  logic                   in_xact;
  logic                   out_free;
  logic [VALUE_W-1:0]     raw;

  assign chain_bit[0] = mag_r[VALUE_W-1];
  assign top_digit    = dig[NUM_DIGITS-1];

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_low
      assign din[i] = '0;
    end else begin : g_up
      assign din[i] = dig[i-1];
    end
    sitoa_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .bit_in   (chain_bit[i]),
      .digit_in (din[i]),
      .digit    (dig[i]),
      .bit_out  (chain_bit[i+1])
    );
  end

  assign in_ready = (state_r == S_IDLE);
  assign in_xact  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign raw      = in_value;

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    cnt_nxt       = cnt_r;
    left_nxt      = left_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    ctrl          = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xact) begin
          neg_nxt   = raw[VALUE_W-1];
          mag_nxt   = raw[VALUE_W-1] ? (VALUE_W'(0) - raw) : raw;
          cnt_nxt   = '0;
          ctrl.clr  = 1'b1;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        ctrl.conv = 1'b1;
        mag_nxt   = {mag_r[VALUE_W-2:0], 1'b0};
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(VALUE_W - 1)) begin
          left_nxt  = LEFT_W'(NUM_DIGITS);
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        // drop leading zeros, keeping at least one digit
        if (top_digit == '0 && left_r > LEFT_W'(1)) begin
          ctrl.dshift = 1'b1;
          left_nxt    = left_r - 1'b1;
        end else begin
          state_nxt = neg_r ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CHAR_ZERO + {4'b0, top_digit};
          out_last_nxt  = (left_r == LEFT_W'(1));
          ctrl.dshift   = 1'b1;
          left_nxt      = left_r - 1'b1;
          if (left_r == LEFT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    cnt_r      <= cnt_nxt;
    left_r     <= left_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

FILE: sv/sitoa_cell.sv
`timescale 1ns / 1ps

// One BCD digit. In conversion mode it does the add-3 adjust and shifts in
// a bit from the lower neighbor; in digit-shift mode it takes the lower
// neighbor's whole digit.
module sitoa_cell (
  input  logic                  clk,
  input  sitoa_pkg::cell_ctrl_t ctrl,
  input  logic                  bit_in,
  input  sitoa_pkg::bcd_t       digit_in,
  output sitoa_pkg::bcd_t       digit,
  output logic                  bit_out
);
  import sitoa_pkg::*;

  bcd_t digit_r;
  bcd_t digit_nxt;
  bcd_t adj;

  always_comb begin
    adj       = (digit_r >= 4'd5) ? bcd_t'(digit_r + 4'd3) : digit_r;
    digit_nxt = digit_r;
    priority if (ctrl.clr) begin
      digit_nxt = '0;
    end else if (ctrl.conv) begin
      digit_nxt = {adj[2:0], bit_in};
    end else if (ctrl.dshift) begin
      digit_nxt = digit_in;
    end else begin
      digit_nxt = digit_r;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

  assign digit   = digit_r;
  assign bit_out = adj[3];

endmodule

FILE: sv/sitoa_checker.sv
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_macros.svh"

module sitoa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_character,
  input logic        out_last
);
  import sitoa_pkg::*;

  logic is_digit;
  logic is_minus;

  assign is_minus = (out_character == CHAR_MINUS);
  assign is_digit = (out_character >= CHAR_ZERO) && (out_character <= 8'd57);

  `SITOA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_character) && $stable(out_last))
  `SITOA_ASSERT_IMPL(a_char_set, clk, rst_n, out_valid, is_minus || is_digit)
  `SITOA_ASSERT_IMPL(a_minus_not_last, clk, rst_n, out_valid && is_minus, !out_last)
  `SITOA_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready)
  `SITOA_ASSERT_IMPL(a_busy_mid_text, clk, rst_n, out_valid && !out_last, !in_ready)

endmodule

bind signed_int_to_decimal_ascii sitoa_checker u_sitoa_checker (.*);
